// ----- hw/rtl/bfwm_pkg.sv -----
// bfwm_pkg: operation codes, status codes and field widths of the byte FIFO
// with drain watermark. No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bfwm_pkg;

	// Field widths fixed by the interface
	localparam int KIND_W   = 3;
	localparam int DATA_W   = 8;
	localparam int COUNT_W  = 5;
	localparam int DEPTH_W  = 11;
	localparam int STATUS_W = 2;
	localparam int CAP_W    = 12;

	// Reset value of the soft capacity register
	localparam logic [CAP_W-1:0] CAP_RESET = 12'd1024;

	// Operation codes carried in kind
	localparam logic [KIND_W-1:0] KIND_PUSH    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PULL    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FINISH  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_FAIL    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CONSUME = 3'd4;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

	typedef logic [DATA_W-1:0] byte_t;

endpackage

// ----- hw/rtl/bfwm_store.sv -----
// bfwm_store: byte RAM with one write port and one read port, read data
// registered. Depends on bfwm_pkg for the byte type.
`timescale 1ns / 1ps

module bfwm_store import bfwm_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  byte_t         wr_data,
	input  logic [AW-1:0] rd_addr,
	output byte_t         rd_data
);

	byte_t mem [DEPTH];

	// Write one byte
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read every cycle, data lands in the following cycle
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- hw/rtl/byte_fifo_with_drain_watermark_top.sv -----
// byte_fifo_with_drain_watermark_top: byte FIFO in a circular RAM with a
// drain watermark flag. Depends on bfwm_pkg and bfwm_store.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake              Payload
// command   in         start & !busy          kind, data_in, byte_count
// result    out        strobe (one cycle)     data_out, data_valid, last, depth,
//                                             status, finished, failed, at_eof,
//                                             drain_flag
// config    in         cfg_wr_en              cfg_wr_data (soft capacity)
//
// For push, finish, fail, consume and an empty or rejected pull the result is
// on the ports the cycle after the command beat and busy stays low, so one
// such command can follow every cycle. A pull that hands out N bytes reads
// them one byte a cycle through the RAM read port; busy holds until the last
// byte leaves the read stage. Reset clears pointers, fill count and flags;
// RAM contents are not cleared. The receiver cannot stall: every result beat
// is taken in the cycle it is shown.

module byte_fifo_with_drain_watermark_top import bfwm_pkg::*; #(
	parameter int DEPTH     = 1024,
	parameter int MAX_BURST = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [KIND_W-1:0]   kind,
	input  logic [DATA_W-1:0]   data_in,
	input  logic [COUNT_W-1:0]  byte_count,
	input  logic                cfg_wr_en,
	input  logic [CAP_W-1:0]    cfg_wr_data,
	output logic                strobe,
	output logic [DATA_W-1:0]   data_out,
	output logic                data_valid,
	output logic                last,
	output logic [DEPTH_W-1:0]  depth,
	output logic [STATUS_W-1:0] status,
	output logic                finished,
	output logic                failed,
	output logic                at_eof,
	output logic                drain_flag
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int TW = $clog2(MAX_BURST + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_PULL = 1'b1;

	// Control state
	logic              state_q;
	logic [PW-1:0]     rptr_q;
	logic [PW-1:0]     wptr_q;
	logic [CW-1:0]     fill_q;
	logic              above_q;
	logic              drain_q;
	logic              end_q;
	logic              abort_q;
	logic [CAP_W-1:0]  cap_q;
	logic [PW-1:0]     raddr_q;
	logic [TW-1:0]     rem_q;
	logic              valid_s1;
	logic              last_s1;

	// Command decode
	logic              accept;
	logic [TW-1:0]     sat_cnt;
	logic [TW-1:0]     take;
	logic [DEPTH_W-1:0] wm;
	logic              push_ok;
	logic              pull_go;
	logic [CW-1:0]     fill_d;
	logic              above_d;
	logic              drain_d;
	logic              end_d;
	logic              abort_d;
	logic              drain_res;
	logic [STATUS_W-1:0] status_d;
	logic [PW:0]       rsum;
	logic [PW-1:0]     rptr_adv;
	logic [PW-1:0]     rd_addr;
	byte_t             rd_data;

	assign accept = start && !busy;
	assign busy   = (state_q == ST_PULL) || valid_s1;

	// Watermark is half the soft capacity, at least one
	assign wm = (cap_q[CAP_W-1:1] == '0) ? DEPTH_W'(1) : DEPTH_W'(cap_q[CAP_W-1:1]);

	// Saturate the request, then limit it to what is buffered
	always_comb begin
		if (32'(byte_count) > MAX_BURST) begin
			sat_cnt = TW'(MAX_BURST);
		end else begin
			sat_cnt = TW'(byte_count);
		end
		if (32'(fill_q) < 32'(sat_cnt)) begin
			take = TW'(fill_q);
		end else begin
			take = sat_cnt;
		end
	end

	// Read pointer after a burst, wrapped once
	always_comb begin
		rsum = (PW + 1)'(rptr_q) + (PW + 1)'(take);
		if (rsum >= (PW + 1)'(DEPTH)) begin
			rsum = rsum - (PW + 1)'(DEPTH);
		end
		rptr_adv = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
	end

	// Next state and result fields for the command beat
	always_comb begin
		fill_d    = fill_q;
		above_d   = above_q;
		drain_d   = drain_q;
		end_d     = end_q;
		abort_d   = abort_q;
		status_d  = ST_OK;
		push_ok   = 1'b0;
		pull_go   = 1'b0;
		case (kind)
			KIND_PUSH: begin
				if (end_q || abort_q) begin
					status_d = ST_REJECT;
				end else begin
					if (32'(fill_q) >= DEPTH) begin
						status_d = ST_FULL;
					end else begin
						push_ok = 1'b1;
						fill_d  = fill_q + 1'b1;
					end
					if (32'(fill_d) >= 32'(wm)) begin
						above_d = 1'b1;
					end
				end
			end
			KIND_PULL: begin
				if (abort_q) begin
					status_d = ST_REJECT;
				end else if (take == '0) begin
					status_d = ST_EMPTY;
				end else begin
					pull_go = 1'b1;
					fill_d  = fill_q - CW'(take);
					if (above_q && (32'(fill_d) < 32'(wm))) begin
						above_d = 1'b0;
						drain_d = 1'b1;
					end
				end
			end
			KIND_FINISH: begin
				end_d = 1'b1;
			end
			KIND_FAIL: begin
				abort_d = 1'b1;
				fill_d  = '0;
			end
			KIND_CONSUME: begin
				drain_d = 1'b0;
			end
			default: begin
			end
		endcase
		drain_res = (kind == KIND_CONSUME) ? drain_q : drain_d;
	end

	// Read the head in the command cycle, then walk the burst
	assign rd_addr = (state_q == ST_IDLE) ? rptr_q : raddr_q;

	bfwm_store #(
		.DEPTH (DEPTH),
		.AW    (PW)
	) u_store (
		.clk     (clk),
		.wr_en   (accept && push_ok),
		.wr_addr (wptr_q),
		.wr_data (data_in),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Soft capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// FIFO state, burst sequencer and read stage tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rptr_q   <= '0;
			wptr_q   <= '0;
			fill_q   <= '0;
			above_q  <= 1'b0;
			drain_q  <= 1'b0;
			end_q    <= 1'b0;
			abort_q  <= 1'b0;
			raddr_q  <= '0;
			rem_q    <= '0;
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fill_q  <= fill_d;
						above_q <= above_d;
						drain_q <= drain_d;
						end_q   <= end_d;
						abort_q <= abort_d;
						if (push_ok) begin
							wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
						end
						if (kind == KIND_FAIL) begin
							rptr_q <= '0;
							wptr_q <= '0;
						end
						if (pull_go) begin
							rptr_q   <= rsum[PW-1:0];
							raddr_q  <= rptr_adv;
							rem_q    <= take - 1'b1;
							valid_s1 <= 1'b1;
							last_s1  <= (take == TW'(1));
							if (take != TW'(1)) begin
								state_q <= ST_PULL;
							end
						end
					end
				end
				ST_PULL: begin
					valid_s1 <= 1'b1;
					last_s1  <= (rem_q == TW'(1));
					rem_q    <= rem_q - 1'b1;
					raddr_q  <= (raddr_q == PW'(DEPTH - 1)) ? '0 : raddr_q + 1'b1;
					if (rem_q == TW'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= valid_s1 || (accept && !pull_go);
		end
	end

	// Result payload: a byte beat from the read stage, or the command's status beat
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			data_out   <= rd_data;
			data_valid <= 1'b1;
			last       <= last_s1;
			depth      <= DEPTH_W'(fill_q);
			status     <= ST_OK;
			finished   <= end_q;
			failed     <= abort_q;
			at_eof     <= end_q && (fill_q == '0);
			drain_flag <= drain_q;
		end else begin
			data_out   <= '0;
			data_valid <= 1'b0;
			last       <= 1'b1;
			depth      <= DEPTH_W'(fill_d);
			status     <= status_d;
			finished   <= end_d;
			failed     <= abort_d;
			at_eof     <= end_d && (fill_d == '0);
			drain_flag <= drain_res;
		end
	end

endmodule

// ----- dv/byte_fifo_with_drain_watermark_top_tb.sv -----
// Self-checking bench for byte_fifo_with_drain_watermark_top: drives push, pull,
// finish, fail and consume commands and checks every result beat against a
// built-in FIFO predictor. Depends on bfwm_pkg and the block's RTL.
`timescale 1ns / 1ps

module byte_fifo_with_drain_watermark_top_tb;
	import bfwm_pkg::*;

	localparam int FIFO_DEPTH  = 1024;
	localparam int BURST_MAX   = 16;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PRINT_LIMIT = 100;

	typedef struct {
		logic [KIND_W-1:0]  kind;
		byte_t              data;
		logic [COUNT_W-1:0] count;
	} command_t;

	typedef struct {
		byte_t               data_out;
		logic                data_valid;
		logic                last;
		logic [DEPTH_W-1:0]  depth;
		logic [STATUS_W-1:0] status;
		logic                finished;
		logic                failed;
		logic                at_eof;
		logic                drain_flag;
	} response_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [KIND_W-1:0]   kind = KIND_CONSUME;
	logic [DATA_W-1:0]   data_in = '0;
	logic [COUNT_W-1:0]  byte_count = '0;
	logic                cfg_wr_en = 1'b0;
	logic [CAP_W-1:0]    cfg_wr_data = '0;
	logic                strobe;
	logic [DATA_W-1:0]   data_out;
	logic                data_valid;
	logic                last;
	logic [DEPTH_W-1:0]  depth;
	logic [STATUS_W-1:0] status;
	logic                finished;
	logic                failed;
	logic                at_eof;
	logic                drain_flag;

	byte_fifo_with_drain_watermark_top #(
		.DEPTH(FIFO_DEPTH),
		.MAX_BURST(BURST_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.data_in(data_in),
		.byte_count(byte_count),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.strobe(strobe),
		.data_out(data_out),
		.data_valid(data_valid),
		.last(last),
		.depth(depth),
		.status(status),
		.finished(finished),
		.failed(failed),
		.at_eof(at_eof),
		.drain_flag(drain_flag)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: mirror of the circular store, pointers and flags
	byte_t            mirror_mem [FIFO_DEPTH];
	int unsigned      rd_idx = 0;
	int unsigned      wr_idx = 0;
	int unsigned      fill = 0;
	bit               armed = 1'b0;
	bit               drain_pend = 1'b0;
	bit               ended = 1'b0;
	bit               aborted = 1'b0;
	logic [CAP_W-1:0] soft_cap = CAP_RESET;

	command_t  command_backlog[$];
	response_t owed_results[$];
	int        mismatch_count = 0;
	int        cycle_count = 0;
	bit        cmd_held = 1'b0;

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_LIMIT)
			$display("%0t mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	// Advance the mirror by one accepted command and queue the beats it owes
	function automatic void apply_command(input command_t c);
		int unsigned         mark;
		int unsigned         want;
		int unsigned         take;
		int unsigned         i;
		logic [STATUS_W-1:0] st;
		bit                  drain_seen;
		byte_t               got [BURST_MAX];
		response_t           r;
		mark = 32'(soft_cap) / 2;
		if (mark == 0)
			mark = 1;
		st = ST_OK;
		take = 0;
		drain_seen = 1'b0;
		case (c.kind)
			KIND_PUSH: begin
				if (ended || aborted) begin
					st = ST_REJECT;
				end else begin
					if (fill >= FIFO_DEPTH) begin
						st = ST_FULL;
					end else begin
						mirror_mem[wr_idx] = c.data;
						wr_idx = (wr_idx + 1) % FIFO_DEPTH;
						fill++;
					end
					// arm check runs even when the byte was dropped
					if (fill >= mark)
						armed = 1'b1;
				end
			end
			KIND_PULL: begin
				if (aborted) begin
					st = ST_REJECT;
				end else begin
					want = (32'(c.count) > BURST_MAX) ? BURST_MAX : 32'(c.count);
					take = (want < fill) ? want : fill;
					if (take == 0) begin
						st = ST_EMPTY;
					end else begin
						for (i = 0; i < take; i++) begin
							got[i] = mirror_mem[rd_idx];
							rd_idx = (rd_idx + 1) % FIFO_DEPTH;
						end
						fill -= take;
						if (armed && fill < mark) begin
							armed = 1'b0;
							drain_pend = 1'b1;
						end
					end
				end
			end
			KIND_FINISH: ended = 1'b1;
			KIND_FAIL: begin
				aborted = 1'b1;
				rd_idx = 0;
				wr_idx = 0;
				fill = 0;
			end
			KIND_CONSUME: begin
				drain_seen = drain_pend;
				drain_pend = 1'b0;
			end
			default: ;
		endcase
		r.depth = fill[DEPTH_W-1:0];
		r.finished = ended;
		r.failed = aborted;
		r.at_eof = ended && fill == 0;
		r.drain_flag = (c.kind == KIND_CONSUME) ? drain_seen : drain_pend;
		if (take > 0) begin
			for (i = 0; i < take; i++) begin
				r.data_out = got[i];
				r.data_valid = 1'b1;
				r.last = (i + 1 == take);
				r.status = ST_OK;
				owed_results.push_back(r);
			end
		end else begin
			r.data_out = '0;
			r.data_valid = 1'b0;
			r.last = 1'b1;
			r.status = st;
			owed_results.push_back(r);
		end
	endfunction

	// Command driver: send beats in bursts with random gaps between them
	int unsigned burst_left = 4;
	int unsigned gap_left = 0;
	command_t    held;

	always @(posedge clk) begin : command_driver
		bit next_start;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			next_start = start;
			if (start && !busy) begin
				apply_command(held);
				next_start = 1'b0;
			end
			if (!next_start) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (command_backlog.size() > 0) begin
					held = command_backlog.pop_front();
					kind <= held.kind;
					data_in <= held.data;
					byte_count <= held.count;
					next_start = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
						gap_left = $urandom_range(0, 6);
					end
				end
			end
			cmd_held = next_start;
			start <= next_start;
		end
	end

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	// Result monitor: compare every strobed beat with the oldest owed one
	always @(posedge clk) begin : result_monitor
		response_t w;
		if (arst_n && strobe === 1'b1) begin
			if (owed_results.size() == 0) begin
				report_mismatch("result beat with nothing outstanding");
			end else begin
				w = owed_results.pop_front();
				check_field("data_out", 16'(data_out), 16'(w.data_out));
				check_field("data_valid", 16'(data_valid), 16'(w.data_valid));
				check_field("last", 16'(last), 16'(w.last));
				check_field("depth", 16'(depth), 16'(w.depth));
				check_field("status", 16'(status), 16'(w.status));
				check_field("finished", 16'(finished), 16'(w.finished));
				check_field("failed", 16'(failed), 16'(w.failed));
				check_field("at_eof", 16'(at_eof), 16'(w.at_eof));
				check_field("drain_flag", 16'(drain_flag), 16'(w.drain_flag));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[byte_fifo_with_drain_watermark_top] ERROR");
			$finish;
		end
	end

	function automatic command_t make_cmd(input logic [KIND_W-1:0] k,
			input byte_t d, input logic [COUNT_W-1:0] n);
		command_t c;
		c.kind = k;
		c.data = d;
		c.count = n;
		return c;
	endfunction

	// Random command with random payload; finish and fail only when allowed
	function automatic command_t random_cmd(input bit allow_close);
		int unsigned pick;
		command_t    c;
		pick = $urandom_range(0, 99);
		c.data = byte_t'($urandom_range(0, 255));
		c.count = ($urandom_range(0, 9) == 0) ? COUNT_W'($urandom_range(17, 31))
			: COUNT_W'($urandom_range(0, 16));
		if (pick < 46)
			c.kind = KIND_PUSH;
		else if (pick < 76)
			c.kind = KIND_PULL;
		else if (pick < 88)
			c.kind = KIND_CONSUME;
		else if (pick < 94)
			c.kind = KIND_W'($urandom_range(5, 7));
		else if (allow_close)
			c.kind = ($urandom_range(0, 1) == 0) ? KIND_FINISH : KIND_FAIL;
		else
			c.kind = KIND_PUSH;
		return c;
	endfunction

	// Hold until every queued command is taken and every owed beat has come
	task automatic wait_until_drained();
		do
			@(posedge clk);
		while (command_backlog.size() != 0 || cmd_held || busy || owed_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_soft_capacity(input logic [CAP_W-1:0] v);
		wait_until_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		soft_cap = v;
	endtask

	logic [CAP_W-1:0] phase_caps [6];
	int               k;

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pulls, byte extremes, saturation, drain signal
		write_soft_capacity(12'd4);
		command_backlog.push_back(make_cmd(KIND_CONSUME, 8'h00, 5'd0));
		command_backlog.push_back(make_cmd(KIND_PULL, 8'h00, 5'd0));
		command_backlog.push_back(make_cmd(KIND_PULL, 8'hFF, 5'd5));
		command_backlog.push_back(make_cmd(KIND_PUSH, 8'h00, 5'd31));
		command_backlog.push_back(make_cmd(KIND_PUSH, 8'hFF, 5'd0));
		command_backlog.push_back(make_cmd(KIND_PUSH, 8'hA5, 5'd0));
		command_backlog.push_back(make_cmd(KIND_PULL, 8'h00, 5'd0));
		command_backlog.push_back(make_cmd(KIND_PULL, 8'h00, 5'd31));
		command_backlog.push_back(make_cmd(KIND_CONSUME, 8'h00, 5'd0));
		command_backlog.push_back(make_cmd(KIND_CONSUME, 8'h00, 5'd0));
		command_backlog.push_back(make_cmd(3'd5, 8'h12, 5'd1));
		command_backlog.push_back(make_cmd(3'd6, 8'h34, 5'd2));
		command_backlog.push_back(make_cmd(3'd7, 8'h56, 5'd3));
		command_backlog.push_back(make_cmd(KIND_PUSH, 8'h5A, 5'd0));
		command_backlog.push_back(make_cmd(KIND_PUSH, 8'h01, 5'd0));
		command_backlog.push_back(make_cmd(KIND_PUSH, 8'h80, 5'd0));
		command_backlog.push_back(make_cmd(KIND_PULL, 8'h00, 5'd1));
		command_backlog.push_back(make_cmd(KIND_PULL, 8'h00, 5'd16));
		command_backlog.push_back(make_cmd(KIND_CONSUME, 8'h00, 5'd0));

		// Fill past the watermark, then drain below it in saturated pulls
		write_soft_capacity(12'd40);
		for (k = 0; k < 24; k++)
			command_backlog.push_back(make_cmd(KIND_PUSH,
				byte_t'($urandom_range(0, 255)), 5'd0));
		command_backlog.push_back(make_cmd(KIND_CONSUME, 8'h00, 5'd0));
		for (k = 0; k < 3; k++)
			command_backlog.push_back(make_cmd(KIND_PULL, 8'h00,
				COUNT_W'($urandom_range(16, 31))));
		command_backlog.push_back(make_cmd(KIND_CONSUME, 8'h00, 5'd0));

		// Random traffic across several watermark settings
		phase_caps[0] = 12'd0;
		phase_caps[1] = 12'd1;
		phase_caps[2] = 12'd4095;
		phase_caps[3] = CAP_W'($urandom_range(2, 40));
		phase_caps[4] = CAP_W'($urandom_range(5, 60));
		phase_caps[5] = CAP_W'($urandom_range(0, 4095));
		foreach (phase_caps[p]) begin
			write_soft_capacity(phase_caps[p]);
			for (k = 0; k < 12; k++)
				command_backlog.push_back(random_cmd(1'b0));
		end

		// Close the stream: finish and run random traffic, then abort and send more
		write_soft_capacity(CAP_W'($urandom_range(2, 12)));
		for (k = 0; k < 10; k++)
			command_backlog.push_back(make_cmd(KIND_PUSH,
				byte_t'($urandom_range(0, 255)), 5'd0));
		command_backlog.push_back(make_cmd(KIND_FINISH, 8'h00, 5'd0));
		command_backlog.push_back(make_cmd(KIND_PUSH, 8'h77, 5'd0));
		for (k = 0; k < 10; k++)
			command_backlog.push_back(random_cmd(1'b0));
		command_backlog.push_back(make_cmd(KIND_FAIL, 8'h00, 5'd0));
		command_backlog.push_back(make_cmd(KIND_PUSH, 8'h3C, 5'd0));
		command_backlog.push_back(make_cmd(KIND_PULL, 8'h00, 5'd4));
		command_backlog.push_back(make_cmd(KIND_FINISH, 8'h00, 5'd0));
		for (k = 0; k < 12; k++)
			command_backlog.push_back(random_cmd(1'b1));

		// Let the last beats arrive, then judge
		do
			@(posedge clk);
		while (command_backlog.size() != 0 || cmd_held);
		for (k = 0; k < 2000 && (owed_results.size() != 0 || busy); k++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (owed_results.size() != 0)
			report_mismatch($sformatf("%0d result beats never arrived", owed_results.size()));
		if (mismatch_count == 0) begin
			$display("[byte_fifo_with_drain_watermark_top] OK");
		end else begin
			$display("[byte_fifo_with_drain_watermark_top] ERROR");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/bfwm_pkg.sv
hw/rtl/bfwm_store.sv
hw/rtl/byte_fifo_with_drain_watermark_top.sv
dv/byte_fifo_with_drain_watermark_top_tb.sv
